FILE: rtl/mkh_pkg.sv
// Shared constants and types of the multi-column key hasher.
package mkh_pkg;

  // Stream field widths.
  localparam int WORD_W = 64;
  localparam int LEN_W  = 16;
  localparam int HALF_W = WORD_W / 2;

  // Largest column length that is honored; longer lengths are clamped.
  localparam logic [LEN_W-1:0] MAX_COLUMN_BYTES = 16'hFFFF;

  // Murmur hash constants.
  localparam logic [WORD_W-1:0] MH_SEED  = 64'h0000_0000_c70f_6907;
  localparam logic [WORD_W-1:0] MH_MUL   = 64'hc6a4_a793_5bd1_e995;
  localparam int                MH_SHIFT = 47;

  // Golden-ratio combine constants.
  localparam logic [WORD_W-1:0] GOLDEN   = 64'h9e37_79b9_7f4a_7c15;
  localparam int                COMB_SHL = 12;
  localparam int                COMB_SHR = 4;

  // Step code of the shared multiplier: one 32x32 partial product per step before DONE.
  localparam logic [1:0] MSTEP_LO_LO = 2'd0;
  localparam logic [1:0] MSTEP_HI_LO = 2'd1;
  localparam logic [1:0] MSTEP_LO_HI = 2'd2;
  localparam logic [1:0] MSTEP_DONE  = 2'd3;

  // Handshake between the sequencer and the shared multiplier.
  typedef struct packed {
    logic go;
    logic done;
  } mul_ctl_t;

  // Murmur shift-xor step.
  function automatic logic [WORD_W-1:0] shift_xor(input logic [WORD_W-1:0] v);
    shift_xor = v ^ (v >> MH_SHIFT);
  endfunction

endpackage

FILE: rtl/multi_column_key_hasher_core.sv
// Top level of the multi-column key hasher: stream ports, sequencer and datapath registers.
//
//  Channel | Direction | Payload
//  --------+-----------+--------------------------------------------------------------
//  in_     | input     | tdata = key_word, column_bytes; tlast = last_word_of_column;
//          |           | tuser = last_column_of_row
//  out_    | output    | tdata = row_hash (one item per row)
//
// Every 64-bit multiply runs through the LO_LO, HI_LO, LO_HI and DONE steps of the shared
// 32x32 multiplier, which sets the rate. A full word passes one decode step and three
// multiplies, a part-word the decode step and one multiply. The first word of a column adds
// the seed multiply, the last word finalization and combine, and a row end the hand-over step.
// The block takes no new item until the current one is finished.
// Reset is synchronous and active low and clears all hash state.
// A row hash still waiting on the output holds the next row end in its hand-over step,
// and no new item is taken until the output register frees.
module multi_column_key_hasher_core
  import mkh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [79:0]       in_tdata,   // [63:0] key_word, [79:64] column_bytes
  input  logic              in_tlast,   // last_word_of_column
  input  logic [0:0]        in_tuser,   // [0] last_column_of_row
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata   // [63:0] row_hash
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SEED   = 10'b00_0000_0010,
    ST_DECIDE = 10'b00_0000_0100,
    ST_BODY1  = 10'b00_0000_1000,
    ST_BODY2  = 10'b00_0001_0000,
    ST_BODY3  = 10'b00_0010_0000,
    ST_TAIL   = 10'b00_0100_0000,
    ST_FIN    = 10'b00_1000_0000,
    ST_COMB   = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic               open_r, open_nxt;
  logic [LEN_W-1:0]   bc_r, bc_nxt;
  logic [WORD_W-1:0]  ch_r, ch_nxt;
  logic [WORD_W-1:0]  comb_r, comb_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_data_r, out_data_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               lastw_r, lastw_nxt;
  logic               lastc_r, lastc_nxt;
  logic [WORD_W-1:0]  op_r, op_nxt;
  logic [2:0]         rem_r, rem_nxt;

  logic [LEN_W-1:0]   in_len;
  logic [LEN_W-1:0]   rem_full;
  logic [WORD_W-1:0]  tail_word;
  logic [WORD_W-1:0]  mul_res;
  mul_ctl_t           mul_ctl;
  logic               in_fire;

  // Shared multiplier.
  assign mul_ctl.go = (state_r == ST_SEED)  || (state_r == ST_BODY1) ||
                      (state_r == ST_BODY2) || (state_r == ST_BODY3) ||
                      (state_r == ST_TAIL)  || (state_r == ST_FIN);

  mkh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_ctl.go),
    .op    (op_r),
    .done  (mul_ctl.done),
    .res   (mul_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Clamp the column length to the supported maximum.
  assign in_len = (in_tdata[79:64] > MAX_COLUMN_BYTES) ? MAX_COLUMN_BYTES : in_tdata[79:64];

  // Bytes still owed by the open column.
  assign rem_full = (len_r > bc_r) ? (len_r - bc_r) : '0;

  // Keep only the remaining bytes of a part-word.
  always_comb begin
    tail_word = word_r;
    for (int i = 0; i < 8; i++) begin
      if (i >= int'(rem_full[2:0])) begin
        tail_word[i*8 +: 8] = 8'h00;
      end
    end
  end

  // Sequencer and datapath.
  always_comb begin
    state_nxt     = state_r;
    open_nxt      = open_r;
    bc_nxt        = bc_r;
    ch_nxt        = ch_r;
    comb_nxt      = comb_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    word_nxt      = word_r;
    len_nxt       = len_r;
    lastw_nxt     = lastw_r;
    lastc_nxt     = lastc_r;
    op_nxt        = op_r;
    rem_nxt       = rem_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          word_nxt  = in_tdata[63:0];
          len_nxt   = in_len;
          lastw_nxt = in_tlast;
          lastc_nxt = in_tuser[0];
          if (!open_r) begin
            // A new column starts from the seed term of its length.
            op_nxt    = {{(WORD_W-LEN_W){1'b0}}, in_len};
            bc_nxt    = '0;
            open_nxt  = 1'b1;
            state_nxt = ST_SEED;
          end else begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_SEED: begin
        if (mul_ctl.done) begin
          ch_nxt    = MH_SEED ^ mul_res;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        rem_nxt = rem_full[2:0];
        if (rem_full >= LEN_W'(8)) begin
          op_nxt    = word_r;
          state_nxt = ST_BODY1;
        end else if (rem_full != '0) begin
          op_nxt    = ch_r ^ tail_word;
          state_nxt = ST_TAIL;
        end else if (lastw_r) begin
          op_nxt    = shift_xor(ch_r);
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BODY1: begin
        if (mul_ctl.done) begin
          op_nxt    = shift_xor(mul_res);
          state_nxt = ST_BODY2;
        end
      end
      ST_BODY2: begin
        if (mul_ctl.done) begin
          op_nxt    = ch_r ^ mul_res;
          state_nxt = ST_BODY3;
        end
      end
      ST_BODY3, ST_TAIL: begin
        if (mul_ctl.done) begin
          ch_nxt = mul_res;
          if (state_r == ST_BODY3) begin
            bc_nxt = bc_r + LEN_W'(8);
          end else begin
            bc_nxt = bc_r + {{(LEN_W-3){1'b0}}, rem_r};
          end
          if (lastw_r) begin
            op_nxt    = shift_xor(mul_res);
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (mul_ctl.done) begin
          op_nxt    = shift_xor(mul_res);
          state_nxt = ST_COMB;
        end
      end
      ST_COMB: begin
        // Fold the finished column hash into the row hash and close the column.
        comb_nxt  = comb_r ^ (op_r + GOLDEN + (comb_r << COMB_SHL) + (comb_r >> COMB_SHR));
        open_nxt  = 1'b0;
        ch_nxt    = '0;
        bc_nxt    = '0;
        state_nxt = lastc_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = comb_r;
          comb_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      open_r      <= 1'b0;
      bc_r        <= '0;
      ch_r        <= '0;
      comb_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      bc_r        <= bc_nxt;
      ch_r        <= ch_nxt;
      comb_r      <= comb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    word_r     <= word_nxt;
    len_r      <= len_nxt;
    lastw_r    <= lastw_nxt;
    lastc_r    <= lastc_nxt;
    op_r       <= op_nxt;
    rem_r      <= rem_nxt;
  end

`ifndef ASSERT_OFF
  // A closed column holds no hash state between items.
  a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !open_r) |-> (bc_r == '0 && ch_r == '0))
    else $error("closed column left hash state behind");

  // The multiplier only finishes while the sequencer waits on it.
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ctl.done |-> mul_ctl.go)
    else $error("multiplier finished outside a multiply step");

  // An accepted item always starts work.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SEED || state_r == ST_DECIDE))
    else $error("accepted item did not start work");

  // A row end with a free output register hands the row hash over at once.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("row hash not handed over");

  // The row hash restarts from zero after each emitted row.
  a_comb_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || out_tready)) |=> (comb_r == '0))
    else $error("row hash not cleared after emit");
`endif

endmodule

FILE: rtl/mkh_mul.sv
// Shared iterative 64-bit multiplier by the Murmur constant (low 64 bits of the product).
module mkh_mul
  import mkh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [WORD_W-1:0] op,
  output logic              done,
  output logic [WORD_W-1:0] res
);

  logic [1:0]          step_r, step_nxt;
  logic [WORD_W-1:0]   acc_r, acc_nxt;
  logic [HALF_W-1:0]   mul_x, mul_y;
  logic [WORD_W-1:0]   prod;

  // Pick the operand halves for this step; the high-by-high term never reaches the low word.
  always_comb begin
    case (step_r)
      MSTEP_LO_LO: begin
        mul_x = op[HALF_W-1:0];
        mul_y = MH_MUL[HALF_W-1:0];
      end
      MSTEP_HI_LO: begin
        mul_x = op[WORD_W-1:HALF_W];
        mul_y = MH_MUL[HALF_W-1:0];
      end
      default: begin
        mul_x = op[HALF_W-1:0];
        mul_y = MH_MUL[WORD_W-1:HALF_W];
      end
    endcase
  end

  // One 32x32 multiplier shared by all steps.
  assign prod = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

  // Accumulate the partial products; cross terms land in the upper half.
  always_comb begin
    acc_nxt  = acc_r;
    step_nxt = '0;
    if (go) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        MSTEP_LO_LO: acc_nxt = prod;
        MSTEP_HI_LO,
        MSTEP_LO_HI: acc_nxt = acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        default:     acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign done = go && (step_r == MSTEP_DONE);
  assign res  = acc_r;

endmodule

FILE: sim/tb_top.sv
// Self-checking stream testbench for the multi-column key hasher core.
module tb_top
  import mkh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One key item as it travels on the input stream.
  typedef struct {
    logic [63:0] key;
    logic [15:0] len;
    logic        last_word;
    logic        last_col;
    bit          hold;       // wait until every expected row hash has come
  } key_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // [63:0] key_word, [79:64] column_bytes
  logic        in_tlast = 1'b0; // last_word_of_column
  logic [0:0]  in_tuser = '0;   // [0] last_column_of_row
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] row_hash

  key_item_t   key_word_q[$];
  logic [63:0] row_hash_q[$];
  key_item_t   cur;
  int          item_total;
  int          items_taken;
  int          fail_count;

  // Predictor state: open column, running row hash.
  bit [63:0]   col_hash;
  bit [63:0]   row_acc;
  bit [15:0]   bytes_done;
  bit          col_open;

  multi_column_key_hasher_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Murmur column step plus golden-ratio row fold; returns 1 when a row hash is due.
  function automatic bit murmur_row_step(input key_item_t it, output logic [63:0] row);
    bit [63:0] k;
    bit [63:0] h;
    bit [63:0] mask;
    bit [31:0] len;
    bit [31:0] rem;
    len = it.len;
    row = '0;
    if (!col_open) begin
      col_hash   = MH_SEED ^ (64'(len) * MH_MUL);
      bytes_done = '0;
      col_open   = 1'b1;
    end
    rem = (len > bytes_done) ? len - bytes_done : 0;
    if (rem >= 8) begin
      k          = it.key * MH_MUL;
      k          = k ^ (k >> MH_SHIFT);
      k          = k * MH_MUL;
      col_hash   = (col_hash ^ k) * MH_MUL;
      bytes_done = bytes_done + 16'd8;
    end else if (rem > 0) begin
      // Key bytes above the remaining count are masked off.
      mask       = (64'd1 << (8 * rem)) - 64'd1;
      col_hash   = (col_hash ^ (it.key & mask)) * MH_MUL;
      bytes_done = bytes_done + rem[15:0];
    end
    if (!it.last_word) return 1'b0;
    h = col_hash ^ (col_hash >> MH_SHIFT);
    h = h * MH_MUL;
    h = h ^ (h >> MH_SHIFT);
    row_acc    = row_acc ^ (h + GOLDEN + (row_acc << COMB_SHL) + (row_acc >> COMB_SHR));
    col_open   = 1'b0;
    col_hash   = '0;
    bytes_done = '0;
    if (!it.last_col) return 1'b0;
    row     = row_acc;
    row_acc = '0;
    return 1'b1;
  endfunction

  // Idle rate per side: sender 38/receiver 48, then swapped, then none.
  function automatic int idle_pct(input bit sender);
    int ph;
    ph = (item_total == 0) ? 0 : items_taken * 3 / item_total;
    if (ph == 0) return sender ? 38 : 48;
    if (ph == 1) return sender ? 48 : 38;
    return 0;
  endfunction

  task automatic add_word(input logic [63:0] key, input logic [15:0] len, input bit lw,
                          input bit lc, input bit hold);
    key_item_t it;
    it.key       = key;
    it.len       = len;
    it.last_word = lw;
    it.last_col  = lc;
    it.hold      = hold;
    key_word_q.insert(key_word_q.size(), it);
  endtask

  // Well-formed column; stray row flags on inner words are ignored by the block.
  task automatic add_column(input int len, input bit row_end, input bit hold);
    int words;
    bit lw;
    words = (len == 0) ? 1 : (len + 7) / 8;
    for (int i = 0; i < words; i++) begin
      lw = (i == words - 1);
      add_word({$urandom, $urandom}, len[15:0], lw,
               lw ? row_end : ($urandom_range(0, 9) == 0), hold && (i == 0));
    end
  endtask

  // Driver: presents queued items and predicts each one on acceptance.
  always @(posedge clk) begin : drive
    logic [63:0] row;
    bit          next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        if (murmur_row_step(cur, row)) row_hash_q.insert(row_hash_q.size(), row);
        items_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid && key_word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)
          && !(key_word_q[0].hold && row_hash_q.size() != 0)) begin
        cur        = key_word_q.pop_front();
        next_valid = 1'b1;
        in_tdata   <= {cur.len, cur.key};
        in_tlast   <= cur.last_word;
        in_tuser   <= cur.last_col;
      end
      in_tvalid <= next_valid;
    end
  end

  // Monitor: checks each row hash against the oldest expectation.
  always @(posedge clk) begin : watch
    logic [63:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (row_hash_q.size() == 0) begin
          $error("row_hash: unexpected item, actual %h", out_tdata);
          fail_count++;
        end else begin
          want = row_hash_q.pop_front();
          if (out_tdata !== want) begin
            $error("row_hash mismatch: expected %h, actual %h", want, out_tdata);
            fail_count++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stim
    int  ncols;
    int  kind;
    int  len;
    int  n;
    int  next_hold;
    bit  rend;
    bit  hold;

    // Zero-length column: key is ignored, only the seed term counts.
    add_word('1, 16'd0, 1, 1, 0);
    // Full zero word, then a 3-byte tail with all key bits set.
    add_word('0, 16'd8, 1, 0, 0);
    add_word('1, 16'd3, 1, 1, 0);
    // Row flag alone on an inner word, then early end of the longest column.
    add_word({$urandom, $urandom}, 16'hFFFF, 0, 1, 0);
    add_word('1, 16'hFFFF, 1, 1, 0);
    // Surplus words after a 5-byte column are ignored.
    add_word({$urandom, $urandom}, 16'd5, 0, 0, 0);
    add_word({$urandom, $urandom}, 16'd5, 0, 0, 0);
    add_word({$urandom, $urandom}, 16'd5, 1, 1, 0);
    // Longest tail alone, then a full word plus a one-byte tail.
    add_word('1, 16'd7, 1, 0, 0);
    add_word({$urandom, $urandom}, 16'd9, 0, 0, 0);
    add_word('1, 16'd9, 1, 1, 0);
    // Column length changing mid-column.
    add_word({$urandom, $urandom}, 16'd16, 0, 0, 0);
    add_word({$urandom, $urandom}, 16'd4, 1, 0, 0);
    add_word({$urandom, $urandom}, 16'd20, 0, 0, 0);
    add_word({$urandom, $urandom}, 16'd24, 0, 0, 0);
    add_word({$urandom, $urandom}, 16'd24, 1, 1, 0);
    // Three columns with an empty one in the middle.
    add_column(12, 0, 0);
    add_column(0, 0, 0);
    add_column(8, 1, 0);

    // Random rows, mostly well formed, with a drain pause now and then.
    next_hold = key_word_q.size();
    while (key_word_q.size() < 820) begin
      hold = (key_word_q.size() >= next_hold);
      if (hold) next_hold += 250;
      ncols = $urandom_range(1, 4);
      for (int c = 0; c < ncols; c++) begin
        rend = (c == ncols - 1);
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          len = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 400) : $urandom_range(0, 40);
          add_column(len, rend, hold);
        end else if (kind < 78) begin
          // Early end of a long column.
          len = $urandom_range(9, 65535);
          n   = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            add_word({$urandom, $urandom}, len[15:0], i == n - 1, (i == n - 1) && rend,
                     hold && i == 0);
        end else if (kind < 86) begin
          // Surplus words past the column length.
          len = $urandom_range(0, 20);
          n   = ((len + 7) / 8) + $urandom_range(1, 2);
          for (int i = 0; i < n; i++)
            add_word({$urandom, $urandom}, len[15:0], i == n - 1, (i == n - 1) && rend,
                     hold && i == 0);
        end else if (kind < 93) begin
          // Length changes after the first word.
          n = $urandom_range(2, 3);
          for (int i = 0; i < n; i++)
            add_word({$urandom, $urandom}, 16'($urandom_range(0, 40)), i == n - 1,
                     (i == n - 1) && rend, hold && i == 0);
        end else begin
          // Noise: arbitrary lengths and flags.
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            add_word({$urandom, $urandom}, 16'($urandom),
                     (i == n - 1) ? 1'b1 : 1'($urandom), (i == n - 1) ? rend : 1'($urandom),
                     hold && i == 0);
        end
        hold = 1'b0;
      end
    end
    item_total = key_word_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (key_word_q.size() != 0 || in_tvalid) @(posedge clk);
    while (row_hash_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (row_hash_q.size() != 0) begin
      $error("row_hash: %0d expected items never arrived", row_hash_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mkh_pkg.sv
rtl/mkh_mul.sv
rtl/multi_column_key_hasher_core.sv
sim/tb_top.sv
